// ===== design/avt_pkg.sv =====
package avt_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_ENTRIES   = 16;
    localparam int INDEX_WIDTH   = 4;

    // Exact product, the product with its fraction bits dropped, and a sum of four terms.
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int TERM_WIDTH = PROD_WIDTH - FRACTION_BITS;
    localparam int SUM_WIDTH  = TERM_WIDTH + 2;

    // Slave tdata layout, from the lowest bit up.
    localparam int S_INDEX_LSB  = 0;
    localparam int S_VALUE_LSB  = S_INDEX_LSB + INDEX_WIDTH;
    localparam int S_X_LSB      = S_VALUE_LSB + COORD_WIDTH;
    localparam int S_Y_LSB      = S_X_LSB + COORD_WIDTH;
    localparam int S_Z_LSB      = S_Y_LSB + COORD_WIDTH;
    localparam int S_USED_BITS  = S_Z_LSB + COORD_WIDTH;
    localparam int S_DATA_WIDTH = ((S_USED_BITS + 7) / 8) * 8;
    localparam int M_DATA_WIDTH = 4 * COORD_WIDTH;

    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TRANSFORM = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [NUM_ENTRIES-1:0][COORD_WIDTH-1:0] matrix_t;
    typedef logic [3:0][COORD_WIDTH-1:0] vec4_t;

    localparam coord_t IDENTITY_ONE = coord_t'(1) << FRACTION_BITS;

    typedef struct packed {
        logic                   en;
        logic [INDEX_WIDTH-1:0] index;
        coord_t                 value;
    } mat_wr_t;

endpackage

// ===== design/avt_matrix_store.sv =====
module avt_matrix_store (
    input  logic              clk,
    input  logic              rst_n,
    input  avt_pkg::mat_wr_t  wr,
    output avt_pkg::matrix_t  mat
);
    import avt_pkg::*;

    coord_t mat_reg [NUM_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Identity: row equals column on the diagonal.
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                mat_reg[i] <= (i[1:0] == i[3:2]) ? IDENTITY_ONE : '0;
            end
        end
        else if (wr.en)
        begin
            mat_reg[wr.index] <= wr.value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            mat[i] = mat_reg[i];
        end
    end

endmodule

// ===== design/avt_row_unit.sv =====
module avt_row_unit (
    input  avt_pkg::coord_t m_col0,
    input  avt_pkg::coord_t m_col1,
    input  avt_pkg::coord_t m_col2,
    input  avt_pkg::coord_t m_trans,
    input  avt_pkg::coord_t vx,
    input  avt_pkg::coord_t vy,
    input  avt_pkg::coord_t vz,
    output avt_pkg::coord_t result,
    output logic            sat
);
    import avt_pkg::*;

    localparam int HEAD = SUM_WIDTH - COORD_WIDTH + 1;

    logic signed [PROD_WIDTH-1:0] p0, p1, p2;
    logic signed [TERM_WIDTH-1:0] t0, t1, t2;
    logic signed [SUM_WIDTH-1:0]  sum;
    logic        [HEAD-1:0]       head;

    assign p0 = m_col0 * vx;
    assign p1 = m_col1 * vy;
    assign p2 = m_col2 * vz;

    // Dropping the low bits of the two's complement product rounds toward minus infinity.
    assign t0 = $signed(p0[PROD_WIDTH-1:FRACTION_BITS]);
    assign t1 = $signed(p1[PROD_WIDTH-1:FRACTION_BITS]);
    assign t2 = $signed(p2[PROD_WIDTH-1:FRACTION_BITS]);

    assign sum = {{(SUM_WIDTH-TERM_WIDTH){t0[TERM_WIDTH-1]}}, t0}
               + {{(SUM_WIDTH-TERM_WIDTH){t1[TERM_WIDTH-1]}}, t1}
               + {{(SUM_WIDTH-TERM_WIDTH){t2[TERM_WIDTH-1]}}, t2}
               + {{(SUM_WIDTH-COORD_WIDTH){m_trans[COORD_WIDTH-1]}}, m_trans};

    // The sum fits when every bit from the result's sign bit upward agrees.
    assign head = sum[SUM_WIDTH-1:COORD_WIDTH-1];
    assign sat  = !((&head) || !(|head));

    always_comb
    begin
        if (!sat)
        begin
            result = sum[COORD_WIDTH-1:0];
        end
        else if (sum[SUM_WIDTH-1])
        begin
            result = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

endmodule

// ===== design/affine_vertex_transform_core.sv =====
// Affine vertex transform: a 4x4 Q16.16 matrix, column-major (entry 4*column+row),
// applied to vertices with w taken as 1.
// Slave channel: s_tuser selects the item kind. A load item writes one matrix
// entry from s_tdata and gives no result; a transform item carries x, y and z.
// Master channel: one item per transform, with the four components in m_tdata
// and a flag in m_tuser that is set when any component sum was clamped.
// A transform accepted into the input register moves on to the result register,
// which presents it. Throughput: one item per cycle, loads and transforms alike,
// unless the receiver stalls; twelve parallel multipliers and four adder trees sit
// between the input and result registers.
// A load takes effect for every transform accepted after it.
// Reset loads the identity matrix and empties both registers.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more transform; further items wait on s_tready.
module affine_vertex_transform_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[3:0], entry_value[35:4], vertex_x[67:36], vertex_y[99:68],
    // vertex_z[131:100], zero padding above
    input  logic [avt_pkg::S_DATA_WIDTH-1:0]  s_tdata,
    // req_type
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [avt_pkg::M_DATA_WIDTH-1:0]  m_tdata,
    // saturated
    output logic [0:0]                        m_tuser
);
    import avt_pkg::*;

    logic    in_valid_reg, in_valid_next;
    coord_t  vx_reg, vy_reg, vz_reg;
    logic    out_valid_reg, out_valid_next;
    vec4_t   res_reg;
    logic    sat_reg;

    logic    s_accept;
    logic    advance;
    mat_wr_t wr;
    matrix_t mat;
    vec4_t   res;
    logic [3:0] row_sat;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign wr.en    = s_accept && (s_tuser[0] == REQ_LOAD);
    assign wr.index = s_tdata[S_VALUE_LSB-1:S_INDEX_LSB];
    assign wr.value = s_tdata[S_X_LSB-1:S_VALUE_LSB];

    avt_matrix_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .mat   (mat)
    );

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        avt_row_unit u_row (
            .m_col0  (mat[r]),
            .m_col1  (mat[4+r]),
            .m_col2  (mat[8+r]),
            .m_trans (mat[12+r]),
            .vx      (vx_reg),
            .vy      (vy_reg),
            .vz      (vz_reg),
            .result  (res[r]),
            .sat     (row_sat[r])
        );
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid && (s_tuser[0] == REQ_TRANSFORM);
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && (s_tuser[0] == REQ_TRANSFORM))
        begin
            vx_reg <= s_tdata[S_Y_LSB-1:S_X_LSB];
            vy_reg <= s_tdata[S_Z_LSB-1:S_Y_LSB];
            vz_reg <= s_tdata[S_USED_BITS-1:S_Z_LSB];
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res;
            sat_reg <= |row_sat;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = res_reg;
    assign m_tuser[0] = sat_reg;

`ifndef SYNTH
    // A transform stuck behind a stalled result blocks the slave side.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while a transform waits behind a stalled result");

    // A load never occupies the input register.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser[0] == REQ_LOAD)) |=> !in_valid_reg)
        else $error("load item entered the transform path");

    // A pending transform moves into the result register when it is free.
    a_transform_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("transform lost between input and result registers");
`endif

endmodule
